[src/ksoa_pkg.sv]
// Shared types, constants and the key table of the key scanner with autorepeat.
package ksoa_pkg;

    // Number of table keys that take part by default
    localparam int KEY_COUNT_DEF = 13;
    localparam int TABLE_SIZE    = 13;

    // Bits of switch word 2
    localparam logic [31:0] OVR_MASK2     = 32'h0000_F0BF;
    localparam logic [31:0] USB_BIT       = 32'h0400_0000;
    localparam logic [31:0] CARD_LOCK_BIT = 32'h0002_0000;
    localparam int          USB_POS       = 26;

    // Reset values of the autorepeat delays, in milliseconds
    localparam logic [15:0] FIRST_DELAY_RST = 16'd500;
    localparam logic [15:0] NEXT_DELAY_RST  = 16'd175;

    localparam logic [15:0] PULSE_MAX = 16'hFFFF;

    // Request commands
    typedef enum logic [2:0] {
        CMD_SCAN         = 3'd0,
        CMD_PRESS        = 3'd1,
        CMD_RELEASE      = 3'd2,
        CMD_RELEASE_ALL  = 3'd3,
        CMD_CLEAR_REPEAT = 3'd4,
        CMD_READ_PULSE   = 3'd5
    } ksoa_cmd_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_REMOTE_MODE = 2'd0,
        REG_FIRST_DELAY = 2'd1,
        REG_NEXT_DELAY  = 2'd2
    } ksoa_reg_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] raw_group0;
        logic [31:0] raw_group1;
        logic [31:0] raw_group2;
        logic        override_on;
        logic [3:0]  key_index;
        logic [31:0] now_ms;
    } ksoa_in_t;

    typedef struct packed {
        logic [31:0] status_group0;
        logic [31:0] status_group1;
        logic [31:0] status_group2;
        logic [3:0]  pressed_key;
        logic [3:0]  clicked_key;
        logic [3:0]  repeat_key;
        logic        usb_level;
        logic [15:0] usb_pulse_length;
    } ksoa_out_t;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic        remote_on;
        logic [15:0] first_delay;
        logic [15:0] next_delay;
    } ksoa_cfg_t;

    // Word-2 bits of a table key; a key is down when all its bits are low
    function automatic logic [31:0] key_bits(input logic [3:0] k);
        logic [31:0] bits;
        unique case (k)
            4'd1:    bits = 32'h0000_3000;
            4'd2:    bits = 32'h0000_2000;
            4'd3:    bits = 32'h0000_0001;
            4'd4:    bits = 32'h0000_0002;
            4'd5:    bits = 32'h0000_1000;
            4'd6:    bits = 32'h0000_0004;
            4'd7:    bits = 32'h0000_0008;
            4'd8:    bits = 32'h0000_0010;
            4'd9:    bits = 32'h0000_0020;
            4'd10:   bits = 32'h0000_0080;
            4'd11:   bits = 32'h0000_4000;
            4'd12:   bits = 32'h0000_8000;
            4'd13:   bits = 32'h0000_0030;
            default: bits = 32'h0000_0000;
        endcase
        return bits;
    endfunction

endpackage

[src/ksoa_core.sv]
// Scan state, virtual-key mask, autorepeat timer and USB pulse counter.
module ksoa_core
    import ksoa_pkg::*;
#(
    parameter int KEY_COUNT = KEY_COUNT_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  ksoa_cfg_t cfg,
    input  ksoa_in_t  item,
    output ksoa_out_t result
);

    logic [31:0] cur0_reg, cur1_reg, cur2_reg;
    logic [31:0] prev2_reg;
    logic [31:0] mask2_reg;
    logic [3:0]  held_reg;
    logic [31:0] last_time_reg;
    logic        started_reg;
    logic [15:0] run_cnt_reg;
    logic [15:0] last_pulse_reg;

    logic [31:0] cur0_next, cur1_next, cur2_next, prev2_next, mask2_next;
    logic [3:0]  held_next;
    logic [31:0] last_time_next;
    logic        started_next;
    logic [15:0] run_cnt_next;
    logic [15:0] last_pulse_next;

    logic [31:0] s2;
    logic        usb;
    logic [3:0]  pressed;
    logic [3:0]  clicked;
    logic [3:0]  rep;
    logic [15:0] pulse_out;
    logic [31:0] elapsed;
    logic [15:0] limit;

    function automatic logic key_valid(input logic [3:0] k);
        return (k >= 4'd1) && (k <= 4'(KEY_COUNT)) && (k <= 4'(TABLE_SIZE));
    endfunction

    function automatic logic key_low(input logic [31:0] w, input logic [3:0] k);
        return (w & key_bits(k)) == 32'h0;
    endfunction

    // Apply the command to the scans and the virtual mask
    always_comb
    begin
        cur0_next  = cur0_reg;
        cur1_next  = cur1_reg;
        cur2_next  = cur2_reg;
        prev2_next = prev2_reg;
        mask2_next = mask2_reg;
        unique case (item.cmd)
            CMD_SCAN:
            begin
                prev2_next = cur2_reg;
                cur0_next  = item.raw_group0;
                cur1_next  = item.raw_group1;
                cur2_next  = item.raw_group2;
            end
            CMD_PRESS:
            begin
                if (key_valid(item.key_index))
                    mask2_next = mask2_reg & ~key_bits(item.key_index);
            end
            CMD_RELEASE:
            begin
                if (key_valid(item.key_index))
                    mask2_next = mask2_reg | key_bits(item.key_index);
            end
            CMD_RELEASE_ALL:  mask2_next = mask2_reg | OVR_MASK2;
            default: ;
        endcase
    end

    // Override the masked key bits and find the first pressed and clicked keys
    always_comb
    begin
        if (item.override_on)
            s2 = (cur2_next | OVR_MASK2) & (~OVR_MASK2 | mask2_next);
        else
            s2 = cur2_next;
        usb     = s2[USB_POS];
        pressed = 4'd0;
        clicked = 4'd0;
        for (int k = TABLE_SIZE; k >= 1; k--)
        begin
            if (key_valid(4'(k)) && key_low(cur2_next, 4'(k)))
            begin
                pressed = 4'(k);
                if (!key_low(prev2_next, 4'(k)))
                    clicked = 4'(k);
            end
        end
    end

    // Advance the USB pulse counter and the autorepeat timer on a scan
    assign elapsed = item.now_ms - last_time_reg;
    assign limit   = started_reg ? cfg.next_delay : cfg.first_delay;

    always_comb
    begin
        run_cnt_next    = run_cnt_reg;
        last_pulse_next = last_pulse_reg;
        last_time_next  = last_time_reg;
        started_next    = started_reg;
        held_next       = held_reg;
        rep             = 4'd0;
        pulse_out       = last_pulse_reg;
        if (item.cmd == CMD_SCAN)
        begin
            if (usb)
            begin
                if (run_cnt_reg != PULSE_MAX)
                    run_cnt_next = run_cnt_reg + 16'd1;
            end
            else if (run_cnt_reg != 16'd0)
            begin
                last_pulse_next = run_cnt_reg;
                run_cnt_next    = 16'd0;
            end
            pulse_out = last_pulse_next;

            if (clicked != 4'd0)
            begin
                held_next      = clicked;
                started_next   = 1'b0;
                last_time_next = item.now_ms;
                rep            = clicked;
            end
            else if (key_valid(held_reg) && key_low(cur2_next, held_reg))
            begin
                if (!elapsed[31] && (elapsed > {16'd0, limit}))
                begin
                    started_next   = 1'b1;
                    last_time_next = item.now_ms;
                    rep            = held_reg;
                end
            end
            else
            begin
                held_next = 4'd0;
            end
        end
        else if (item.cmd == CMD_CLEAR_REPEAT)
        begin
            held_next = 4'd0;
        end
        else if (item.cmd == CMD_READ_PULSE)
        begin
            last_pulse_next = 16'd0;
        end
    end

    // Form the result; drop the card-lock bit, and the USB bit in remote mode
    always_comb
    begin
        result.status_group0    = cur0_next;
        result.status_group1    = cur1_next;
        result.status_group2    = s2 & ~CARD_LOCK_BIT
                                  & (cfg.remote_on ? ~USB_BIT : 32'hFFFF_FFFF);
        result.pressed_key      = pressed;
        result.clicked_key      = clicked;
        result.repeat_key       = rep;
        result.usb_level        = usb;
        result.usb_pulse_length = pulse_out;
    end

    // Hold the state; advance it once per request that moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur0_reg       <= 32'hFFFF_FFFF;
            cur1_reg       <= 32'hFFFF_FFFF;
            cur2_reg       <= 32'hFFFF_FFFF;
            prev2_reg      <= 32'hFFFF_FFFF;
            mask2_reg      <= 32'hFFFF_FFFF;
            held_reg       <= 4'd0;
            last_time_reg  <= 32'd0;
            started_reg    <= 1'b0;
            run_cnt_reg    <= 16'd0;
            last_pulse_reg <= 16'd0;
        end
        else if (step)
        begin
            cur0_reg       <= cur0_next;
            cur1_reg       <= cur1_next;
            cur2_reg       <= cur2_next;
            prev2_reg      <= prev2_next;
            mask2_reg      <= mask2_next;
            held_reg       <= held_next;
            last_time_reg  <= last_time_next;
            started_reg    <= started_next;
            run_cnt_reg    <= run_cnt_next;
            last_pulse_reg <= last_pulse_next;
        end
    end

endmodule

[src/key_scan_override_autorepeat_top.sv]
// Top level of the key scanner with virtual-key override and autorepeat.
//
// Requests arrive on in_valid/in_ready/in_data: a scan of three active-low
// switch words, or a command that presses or releases a virtual key, clears
// the autorepeat key or reads and clears the last USB pulse length. Every
// request gives exactly one result on out_valid/out_ready/out_data: status
// words after override, first pressed and clicked keys, autorepeat key, USB
// level and pulse length.
// A request is captured in an input register, worked on combinationally and
// loaded into the result register, from which its result is offered; a stall
// of the receiver can hold it in the input register. One request is taken
// every cycle while results are taken.
// When the receiver stalls, the result register holds and one more request
// waits in the input register; in_ready then drops until the stall clears.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata, no wait;
// the user must write it only while no request is in flight; not enforced.
// Reset clears both registers' valid flags, sets the scans and the virtual
// mask to all released, clears the timers and counters, disables remote mode
// and restores the 500 ms and 175 ms autorepeat delays.
module key_scan_override_autorepeat_top
    import ksoa_pkg::*;
#(
    parameter int KEY_COUNT = KEY_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  ksoa_in_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output ksoa_out_t   out_data,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    logic      item_valid_reg;
    ksoa_in_t  item_reg;
    logic      res_valid_reg;
    ksoa_out_t res_reg;
    ksoa_cfg_t cfg_reg;
    ksoa_out_t result;
    logic      step;

    // Move the held request on when the result register is free or drains
    assign step     = item_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || step;

    ksoa_core #(
        .KEY_COUNT (KEY_COUNT)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .cfg    (cfg_reg),
        .item   (item_reg),
        .result (result)
    );

    // Capture incoming requests
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ready)
            item_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= in_data;
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (step)
            res_valid_reg <= 1'b1;
        else if (out_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= result;
    end

    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.remote_on   <= 1'b0;
            cfg_reg.first_delay <= FIRST_DELAY_RST;
            cfg_reg.next_delay  <= NEXT_DELAY_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_REMOTE_MODE: cfg_reg.remote_on   <= cfg_wdata[0];
                REG_FIRST_DELAY: cfg_reg.first_delay <= cfg_wdata;
                REG_NEXT_DELAY:  cfg_reg.next_delay  <= cfg_wdata;
                default: ;
            endcase
        end
    end

endmodule

[bench/key_scan_override_autorepeat_top_tb.sv]
// Self-checking bench for the key scanner with virtual-key override and autorepeat.
`timescale 1ns / 100ps

module key_scan_override_autorepeat_top_tb
    import ksoa_pkg::*;
();

    // Key words of switch group 2; a table key is down when all of its bits are low
    localparam int KEYS = 13;
    localparam logic [31:0] KEY_WORD2_BITS [KEYS] = '{
        32'h0000_3000, 32'h0000_2000, 32'h0000_0001, 32'h0000_0002, 32'h0000_1000,
        32'h0000_0004, 32'h0000_0008, 32'h0000_0010, 32'h0000_0020, 32'h0000_0080,
        32'h0000_4000, 32'h0000_8000, 32'h0000_0030
    };
    localparam logic [31:0] OVERRIDE_BITS = 32'h0000_F0BF;
    localparam logic [31:0] USB_LINE      = 32'h0400_0000;
    localparam logic [31:0] CARD_LOCK     = 32'h0002_0000;
    localparam int          USB_BIT_POS   = 26;
    localparam logic [15:0] PULSE_CEILING = 16'hFFFF;
    localparam logic [15:0] DEFAULT_FIRST_MS = 16'd500;
    localparam logic [15:0] DEFAULT_NEXT_MS  = 16'd175;

    // Commands outside the defined set
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 4;
    localparam int PULSE_SCANS  = 100;
    localparam int PHASE_ITEMS  = 75;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic        remote;
        logic [15:0] first_ms;
        logic [15:0] next_ms;
    } delay_setting_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    ksoa_in_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    ksoa_out_t   out_data;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    // Mirror of the block's state and configuration
    logic [31:0] scan_now [3]    = '{default: '1};
    logic [31:0] scan_before [3] = '{default: '1};
    logic [31:0] virtual_keys2   = '1;
    logic [3:0]  held_key        = '0;
    logic [31:0] held_since_ms   = '0;
    logic        repeating       = 1'b0;
    logic [15:0] usb_high_run    = '0;
    logic [15:0] usb_pulse_kept  = '0;
    logic        remote_mode     = 1'b0;
    logic [15:0] first_delay_ms  = DEFAULT_FIRST_MS;
    logic [15:0] next_delay_ms   = DEFAULT_NEXT_MS;

    ksoa_out_t   pending_scan_results [$];
    int          fail_count  = 0;
    int          quiet_cycles = 0;
    int          gap_pct   = 0;
    int          stall_pct = 0;

    // Stimulus generator state: key held by the operator, USB level, tick count
    logic [3:0]  gen_key = '0;
    logic        gen_usb = 1'b0;
    logic [31:0] gen_ms  = '0;

    key_scan_override_autorepeat_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5;
        clk = 1'b1;
        #5;
        clk = 1'b0;
    end

    // Stall the result side at random
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Drop the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic table_key(logic [3:0] k);
        return (k >= 1) && (k <= KEYS);
    endfunction

    function automatic logic is_down(logic [31:0] word2, logic [3:0] k);
        return (word2 & KEY_WORD2_BITS[k - 4'd1]) == 32'd0;
    endfunction

    function automatic logic [3:0] first_down(logic [31:0] word2);
        for (int k = 1; k <= KEYS; k++)
            if (is_down(word2, 4'(k)))
                return 4'(k);
        return '0;
    endfunction

    function automatic logic [3:0] first_click(logic [31:0] was, logic [31:0] word2);
        for (int k = 1; k <= KEYS; k++)
            if (!is_down(was, 4'(k)) && is_down(word2, 4'(k)))
                return 4'(k);
        return '0;
    endfunction

    // Work out the result of one request and advance the mirrored state
    function automatic ksoa_out_t predict_scan_result(ksoa_in_t req);
        ksoa_out_t   res;
        logic [31:0] word2;
        logic [31:0] elapsed;
        logic [31:0] limit;
        logic [3:0]  pressed;
        logic [3:0]  clicked;
        logic [3:0]  rep;
        logic [15:0] pulse;
        logic        usb;
        case (req.cmd)
            CMD_SCAN:
            begin
                scan_before = scan_now;
                scan_now[0] = req.raw_group0;
                scan_now[1] = req.raw_group1;
                scan_now[2] = req.raw_group2;
            end
            CMD_PRESS:
                if (table_key(req.key_index))
                    virtual_keys2 &= ~KEY_WORD2_BITS[req.key_index - 4'd1];
            CMD_RELEASE:
                if (table_key(req.key_index))
                    virtual_keys2 |= KEY_WORD2_BITS[req.key_index - 4'd1];
            CMD_RELEASE_ALL:
                virtual_keys2 |= OVERRIDE_BITS;
            CMD_CLEAR_REPEAT:
                held_key = '0;
            default:
                ;
        endcase

        // Overlay the virtual keys on the masked bits of word 2
        word2 = scan_now[2];
        if (req.override_on)
            word2 = (word2 | OVERRIDE_BITS) & (~OVERRIDE_BITS | virtual_keys2);
        usb     = word2[USB_BIT_POS];
        pressed = first_down(scan_now[2]);
        clicked = first_click(scan_before[2], scan_now[2]);
        rep     = '0;
        pulse   = usb_pulse_kept;

        if (req.cmd == CMD_SCAN)
        begin
            // Measure USB-high runs, saturating
            if (usb)
            begin
                if (usb_high_run != PULSE_CEILING)
                    usb_high_run++;
            end
            else if (usb_high_run != 0)
            begin
                usb_pulse_kept = usb_high_run;
                usb_high_run   = '0;
            end
            pulse = usb_pulse_kept;

            // Autorepeat: a click restarts the timer, a held key repeats once it expires
            if (clicked != 0)
            begin
                held_key      = clicked;
                repeating     = 1'b0;
                held_since_ms = req.now_ms;
                rep           = clicked;
            end
            else if (table_key(held_key) && is_down(scan_now[2], held_key))
            begin
                elapsed = req.now_ms - held_since_ms;
                limit   = repeating ? 32'(next_delay_ms) : 32'(first_delay_ms);
                if (!elapsed[31] && elapsed > limit)
                begin
                    repeating     = 1'b1;
                    held_since_ms = req.now_ms;
                    rep           = held_key;
                end
            end
            else
                held_key = '0;
        end
        else if (req.cmd == CMD_READ_PULSE)
            usb_pulse_kept = '0;

        if (remote_mode)
            word2 &= ~(CARD_LOCK | USB_LINE);
        word2 &= ~CARD_LOCK;

        res.status_group0    = scan_now[0];
        res.status_group1    = scan_now[1];
        res.status_group2    = word2;
        res.pressed_key      = pressed;
        res.clicked_key      = clicked;
        res.repeat_key       = rep;
        res.usb_level        = usb;
        res.usb_pulse_length = pulse;
        return res;
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    // Check each result against the oldest outstanding request
    always @(posedge clk)
    begin
        ksoa_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_scan_results.size() == 0)
            begin
                $error("result with no request outstanding: %h", out_data);
                fail_count++;
            end
            else
            begin
                want = pending_scan_results.pop_front();
                compare_field("status_group0", want.status_group0, out_data.status_group0);
                compare_field("status_group1", want.status_group1, out_data.status_group1);
                compare_field("status_group2", want.status_group2, out_data.status_group2);
                compare_field("pressed_key", 32'(want.pressed_key), 32'(out_data.pressed_key));
                compare_field("clicked_key", 32'(want.clicked_key), 32'(out_data.clicked_key));
                compare_field("repeat_key", 32'(want.repeat_key), 32'(out_data.repeat_key));
                compare_field("usb_level", 32'(want.usb_level), 32'(out_data.usb_level));
                compare_field("usb_pulse_length", 32'(want.usb_pulse_length),
                              32'(out_data.usb_pulse_length));
            end
        end
    end

    function automatic ksoa_in_t make_request(logic [2:0] cmd, logic [31:0] g0,
                                              logic [31:0] g1, logic [31:0] g2,
                                              logic ovr, logic [3:0] key,
                                              logic [31:0] ms);
        ksoa_in_t req;
        req.cmd         = cmd;
        req.raw_group0  = g0;
        req.raw_group1  = g1;
        req.raw_group2  = g2;
        req.override_on = ovr;
        req.key_index   = key;
        req.now_ms      = ms;
        return req;
    endfunction

    task automatic set_idle(idle_mode_t mode);
        gap_pct   = (mode == IDLE_SENDER) ? 59 : (mode == IDLE_BOTH) ? 8 : 0;
        stall_pct = (mode == IDLE_RECEIVER) ? 59 : (mode == IDLE_BOTH) ? 8 : 0;
    endtask

    // Offer one request, hold it until taken, then record its expected result
    task automatic send_request(ksoa_in_t req);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_scan_results.push_back(predict_scan_result(req));
    endtask

    // Hold off new requests until every result is back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_scan_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(ksoa_reg_t idx, logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_REMOTE_MODE: remote_mode    = value[0];
            REG_FIRST_DELAY: first_delay_ms = value;
            REG_NEXT_DELAY:  next_delay_ms  = value;
            default:         ;
        endcase
    endtask

    // Mostly keyboard-like scans with random content, with commands mixed in
    task automatic run_random_requests(int count);
        ksoa_in_t req;
        int       pick;
        for (int n = 0; n < count; n++)
        begin
            req = make_request(CMD_SCAN, $urandom, $urandom, $urandom,
                               1'($urandom_range(1)), 4'($urandom_range(15)), $urandom);
            pick = $urandom_range(99);
            if (pick < 72)
            begin
                // advance the tick count, now and then by a jump or backwards
                pick = $urandom_range(99);
                if (pick < 3)
                    gen_ms = $urandom;
                else if (pick < 6)
                    gen_ms += $urandom_range(70000);
                else if (pick < 8)
                    gen_ms -= $urandom_range(1, 1000);
                else
                    gen_ms += $urandom_range(40);
                if ($urandom_range(99) < 12)
                    gen_key = 4'($urandom_range(KEYS));
                if ($urandom_range(99) < 6)
                    gen_usb = !gen_usb;
                // leave the key bits as noise on a few scans
                if ($urandom_range(99) >= 10)
                begin
                    req.raw_group2 |= OVERRIDE_BITS;
                    if (gen_key != 0)
                        req.raw_group2 &= ~KEY_WORD2_BITS[gen_key - 4'd1];
                end
                req.raw_group2[USB_BIT_POS] = gen_usb;
                req.now_ms = gen_ms;
            end
            else if (pick < 75)
                req.cmd = ($urandom_range(1) != 0) ? CMD_SPARE_A : CMD_SPARE_B;
            else
                req.cmd = 3'($urandom_range(CMD_PRESS, CMD_READ_PULSE));
            send_request(req);
        end
    endtask

    // Field extremes, every command, bad key indexes and tick wrap
    task automatic test_directed_cases();
        logic [31:0] key1_only;
        key1_only = ~KEY_WORD2_BITS[0];
        set_idle(IDLE_NONE);
        send_request(make_request(CMD_SCAN, '1, '1, '1, 1'b0, 4'd0, 32'd0));
        send_request(make_request(CMD_SCAN, '0, '0, '0, 1'b0, 4'd0, 32'd10));
        send_request(make_request(CMD_READ_PULSE, '1, '0, '1, 1'b0, 4'd0, '1));
        send_request(make_request(CMD_READ_PULSE, '0, '1, '0, 1'b1, 4'd15, '0));
        send_request(make_request(CMD_PRESS, '0, '0, '0, 1'b1, 4'd0, 32'd20));
        send_request(make_request(CMD_PRESS, '0, '0, '0, 1'b1, 4'd14, 32'd20));
        send_request(make_request(CMD_PRESS, '0, '0, '0, 1'b1, 4'd15, 32'd20));
        send_request(make_request(CMD_PRESS, '0, '0, '0, 1'b1, 4'd3, 32'd20));
        send_request(make_request(CMD_PRESS, '0, '0, '0, 1'b1, 4'd13, 32'd20));
        send_request(make_request(CMD_PRESS, '0, '0, '0, 1'b1, 4'd12, 32'd20));
        send_request(make_request(CMD_RELEASE, '0, '0, '0, 1'b1, 4'd3, 32'd20));
        send_request(make_request(CMD_RELEASE, '0, '0, '0, 1'b1, 4'd0, 32'd20));
        send_request(make_request(CMD_SCAN, '1, '0, '1, 1'b1, 4'd0, 32'd30));
        send_request(make_request(CMD_SPARE_A, '0, '0, '0, 1'b1, 4'd1, 32'd30));
        send_request(make_request(CMD_SPARE_B, '0, '0, '0, 1'b1, 4'd1, 32'd30));
        send_request(make_request(CMD_RELEASE_ALL, '0, '0, '0, 1'b1, 4'd0, 32'd30));
        // hold key 1 across the tick wrap, then step the tick backwards
        send_request(make_request(CMD_SCAN, '0, '1, key1_only, 1'b0, 4'd0, 32'hFFFF_FF00));
        send_request(make_request(CMD_SCAN, '0, '1, key1_only, 1'b0, 4'd0, 32'h0000_0100));
        send_request(make_request(CMD_SCAN, '0, '1, key1_only, 1'b0, 4'd0, 32'h0000_0050));
        send_request(make_request(CMD_SCAN, '0, '1, key1_only, 1'b0, 4'd0, 32'h0000_0200));
        send_request(make_request(CMD_CLEAR_REPEAT, '0, '0, '0, 1'b0, 4'd0, 32'h0000_0300));
        send_request(make_request(CMD_SCAN, '0, '1, key1_only, 1'b0, 4'd0, 32'h0000_1000));
        send_request(make_request(CMD_SCAN, '1, '0, '0, 1'b1, 4'd0, 32'h8000_0000));
    endtask

    // Hold USB high over a long run of scans, end the pulse, then read it back
    task automatic test_pulse_length();
        ksoa_in_t usb_scan;
        usb_scan = make_request(CMD_SCAN, '1, '1, '1, 1'b0, 4'd0, 32'd0);
        set_idle(IDLE_NONE);
        repeat (PULSE_SCANS)
            send_request(usb_scan);
        usb_scan.raw_group2[USB_BIT_POS] = 1'b0;
        send_request(usb_scan);
        send_request(make_request(CMD_READ_PULSE, '0, '0, '0, 1'b0, 4'd0, 32'd0));
    endtask

    // Random traffic under each delay setting and each idling pattern
    task automatic test_random_settings();
        delay_setting_t plan [6];
        plan = '{
            '{1'b0, DEFAULT_FIRST_MS, DEFAULT_NEXT_MS},
            '{1'b1, 16'd0, 16'd0},
            '{1'b0, 16'hFFFF, 16'hFFFF},
            '{1'b1, 16'd20, 16'd5},
            '{1'b0, 16'd3, 16'hFFFF},
            '{1'b1, 16'hFFFF, 16'd0}
        };
        foreach (plan[p])
        begin
            wait_for_results();
            write_reg(REG_REMOTE_MODE, 16'(plan[p].remote));
            write_reg(REG_FIRST_DELAY, plan[p].first_ms);
            write_reg(REG_NEXT_DELAY, plan[p].next_ms);
            for (int m = 0; m < 4; m++)
            begin
                set_idle(idle_mode_t'(m));
                run_random_requests(PHASE_ITEMS);
            end
        end
    endtask

    initial
    begin
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_pulse_length();
        test_random_settings();
        wait_for_results();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
